FILE: hw/rtl/sorf_pkg.sv
// shared constants, types and the scale table for the structured orthogonal random features block
// no dependencies
`default_nettype none
package sorf_pkg;
    localparam int MaxLength   = 1024;
    localparam int SampleWidth = 16;
    localparam int StoreWidth  = 40;
    localparam int ScaleWidth  = 17;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_PULL = 1'b1
    } req_t;

    typedef struct packed {
        logic       pull;
        logic [9:0] addr;
        logic       is_last;
        logic       active;
    } cmd_t;

    function automatic logic [ScaleWidth-1:0] scale_q16(input logic [4:0] l);
        logic [ScaleWidth-1:0] s;
        begin
            case (l)
                5'd0:  s = 17'd65536;
                5'd1:  s = 17'd46341;
                5'd2:  s = 17'd32768;
                5'd3:  s = 17'd23170;
                5'd4:  s = 17'd16384;
                5'd5:  s = 17'd11585;
                5'd6:  s = 17'd8192;
                5'd7:  s = 17'd5793;
                5'd8:  s = 17'd4096;
                5'd9:  s = 17'd2896;
                5'd10: s = 17'd2048;
                5'd11: s = 17'd1448;
                5'd12: s = 17'd1024;
                5'd13: s = 17'd724;
                5'd14: s = 17'd512;
                5'd15: s = 17'd362;
                5'd16: s = 17'd256;
                default: s = 17'd256;
            endcase
            return s;
        end
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/structured_orthogonal_random_features.sv
// Three-round sign flip, 1/sqrt(N) scale and Walsh-Hadamard transform over N = 2^log2_length
// pushed samples; results are pulled one item at a time. The final push starts the transform,
// which runs through the vector memory while no items are taken. Pulls are read from the vector
// memory in the back end, and a push waits until every earlier pull has left the back end.
// depends on sorf_pkg, sorf_front, sorf_queue, sorf_back
`default_nettype none
module structured_orthogonal_random_features #(
    parameter int MAX_LENGTH   = sorf_pkg::MaxLength,
    parameter int SAMPLE_WIDTH = sorf_pkg::SampleWidth
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [3:0]              cfg_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_req_type,
    input  wire logic [SAMPLE_WIDTH-1:0] s_sample,
    input  wire logic                    s_sign_first,
    input  wire logic                    s_sign_second,
    input  wire logic                    s_sign_third,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic                         m_valid_res,
    output logic [SAMPLE_WIDTH-1:0]      m_value,
    output logic                         m_saturated,
    output logic                         m_last
);
    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

    logic [3:0] log2_reg;
    logic ld_we, go, busy, draining, q_push, q_pv, q_last, q_full, q_empty, q_rd, r_v, r_l;
    logic [AW-1:0] ld_addr, q_addr, r_a;
    logic [sorf_pkg::StoreWidth-1:0] ld_data;
    logic [2:0] ld_signs;
    logic [3:0] go_log2;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) log2_reg <= 4'd10;
        else if (cfg_valid) log2_reg <= cfg_data;
    end

    sorf_front #(.MAX_LENGTH(MAX_LENGTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .aclk, .aresetn, .log2_length(log2_reg),
        .s_valid, .s_ready, .s_req_type, .s_sample, .s_sign_first, .s_sign_second,
        .s_sign_third, .ld_we, .ld_addr, .ld_data, .ld_signs, .go, .go_log2, .busy,
        .draining, .q_push, .q_pull_valid(q_pv), .q_addr, .q_last, .q_full
    );

    sorf_queue #(.AW(AW)) u_queue (
        .aclk, .aresetn, .wr(q_push), .wr_valid(q_pv), .wr_addr(q_addr), .wr_last(q_last),
        .full(q_full), .empty(q_empty), .rd(q_rd), .rd_valid(r_v), .rd_addr(r_a),
        .rd_last(r_l)
    );

    sorf_back #(.MAX_LENGTH(MAX_LENGTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
        .aclk, .aresetn, .ld_we, .ld_addr, .ld_data, .ld_signs, .go, .go_log2, .busy,
        .draining, .q_empty, .q_rd, .q_valid(r_v), .q_addr(r_a), .q_last(r_l),
        .m_valid, .m_ready, .m_valid_res, .m_value, .m_saturated, .m_last
    );
endmodule
`default_nettype wire

FILE: hw/rtl/sorf_front.sv
// front end: accepts items, tracks load and drain counts, emits commands to the queue
// depends on sorf_pkg
`default_nettype none
module sorf_front #(
    parameter int MAX_LENGTH   = sorf_pkg::MaxLength,
    parameter int SAMPLE_WIDTH = sorf_pkg::SampleWidth,
    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1,
    localparam int FL = $clog2(MAX_LENGTH + 1) - 1,
    localparam int LMAX = (FL > 10) ? 10 : FL
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic [3:0]              log2_length,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_req_type,
    input  wire logic [SAMPLE_WIDTH-1:0] s_sample,
    input  wire logic                    s_sign_first,
    input  wire logic                    s_sign_second,
    input  wire logic                    s_sign_third,
    // load interface into the store
    output logic                         ld_we,
    output logic [AW-1:0]                ld_addr,
    output logic [sorf_pkg::StoreWidth-1:0] ld_data,
    output logic [2:0]                   ld_signs,
    // transform start
    output logic                         go,
    output logic [3:0]                   go_log2,
    input  wire logic                    busy,
    input  wire logic                    draining,
    // pull command queue
    output logic                         q_push,
    output logic                         q_pull_valid,
    output logic [AW-1:0]                q_addr,
    output logic                         q_last,
    input  wire logic                    q_full
);
    logic [AW:0] load_cnt_reg, load_cnt_next;
    logic [AW:0] drain_cnt_reg, drain_cnt_next;
    logic [AW:0] drain_len_reg, drain_len_next;
    logic        pend_reg, pend_next;
    logic [3:0]  eff;
    logic [AW:0] n;
    logic [AW:0] idx;
    logic        acc;

    always_comb begin
        eff = log2_length;
        if (eff < 4'd1) eff = 4'd1;
        if (eff > 4'(LMAX)) eff = 4'(LMAX);
        n = (AW+1)'(1) << eff;
    end

    // a push waits until earlier pulls have read the store
    assign s_ready = !busy && !q_full && !(s_req_type == sorf_pkg::REQ_PUSH && draining);
    assign acc = s_valid && s_ready;

    always_comb begin
        load_cnt_next  = load_cnt_reg;
        drain_cnt_next = drain_cnt_reg;
        drain_len_next = drain_len_reg;
        pend_next      = pend_reg;
        ld_we = 1'b0;
        go = 1'b0;
        q_push = 1'b0;
        q_pull_valid = 1'b0;
        q_last = 1'b0;
        idx = (load_cnt_reg >= n) ? n - 1'b1 : load_cnt_reg;
        ld_addr = idx[AW-1:0];
        q_addr = drain_cnt_reg[AW-1:0];
        ld_data = {{(sorf_pkg::StoreWidth-SAMPLE_WIDTH-8){s_sample[SAMPLE_WIDTH-1]}},
                   s_sample, 8'd0};
        ld_signs = {s_sign_third, s_sign_second, s_sign_first};
        go_log2 = eff;
        if (acc) begin
            if (s_req_type == sorf_pkg::REQ_PUSH) begin
                if (!pend_reg) begin
                    ld_we = 1'b1;
                    load_cnt_next = idx + 1'b1;
                    if (idx + 1'b1 == n) begin
                        go = 1'b1;
                        pend_next = 1'b1;
                        drain_cnt_next = '0;
                        drain_len_next = n;
                        load_cnt_next = '0;
                    end
                end
            end else begin
                q_push = 1'b1;
                if (pend_reg) begin
                    q_pull_valid = 1'b1;
                    q_last = (drain_cnt_reg + 1'b1 == drain_len_reg);
                    drain_cnt_next = drain_cnt_reg + 1'b1;
                    if (drain_cnt_reg + 1'b1 >= drain_len_reg) begin
                        pend_next = 1'b0;
                        drain_cnt_next = '0;
                        load_cnt_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_cnt_reg  <= '0;
            drain_cnt_reg <= '0;
            drain_len_reg <= (AW+1)'(1);
            pend_reg      <= 1'b0;
        end else begin
            load_cnt_reg  <= load_cnt_next;
            drain_cnt_reg <= drain_cnt_next;
            drain_len_reg <= drain_len_next;
            pend_reg      <= pend_next;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/sorf_queue.sv
// small fifo of pull commands between front and back
// no dependencies
`default_nettype none
module sorf_queue #(
    parameter int AW = 10
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr,
    input  wire logic          wr_valid,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic          wr_last,
    output logic               full,
    output logic               empty,
    input  wire logic          rd,
    output logic               rd_valid,
    output logic [AW-1:0]      rd_addr,
    output logic               rd_last
);
    logic [AW+1:0] mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full  = cnt_reg == 3'd4;
    assign empty = cnt_reg == 3'd0;
    assign {rd_valid, rd_addr, rd_last} = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr) mem[wp_reg] <= {wr_valid, wr_addr, wr_last};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {2'd0, wr} - {2'd0, rd};
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/sorf_back.sv
// back end: vector memory, three-round transform sequencer, and pull result output
// depends on sorf_pkg
`default_nettype none
module sorf_back #(
    parameter int MAX_LENGTH   = sorf_pkg::MaxLength,
    parameter int SAMPLE_WIDTH = sorf_pkg::SampleWidth,
    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    ld_we,
    input  wire logic [AW-1:0]           ld_addr,
    input  wire logic [sorf_pkg::StoreWidth-1:0] ld_data,
    input  wire logic [2:0]              ld_signs,
    input  wire logic                    go,
    input  wire logic [3:0]              go_log2,
    output logic                         busy,
    output logic                         draining,
    input  wire logic                    q_empty,
    output logic                         q_rd,
    input  wire logic                    q_valid,
    input  wire logic [AW-1:0]           q_addr,
    input  wire logic                    q_last,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic                         m_valid_res,
    output logic [SAMPLE_WIDTH-1:0]      m_value,
    output logic                         m_saturated,
    output logic                         m_last
);
    localparam int SW = sorf_pkg::StoreWidth;
    localparam int RW = SW - 7;
    localparam int PW = SW + sorf_pkg::ScaleWidth + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_SC_RD, S_SC_MUL, S_SC_WR, S_BF_RD, S_BF_RD2, S_BF_WR,
        S_PL_RD, S_PL_OUT
    } state_t;

    logic [SW-1:0] vmem [MAX_LENGTH];
    logic [2:0]    smem [MAX_LENGTH];

    state_t        st_reg;
    logic [1:0]    round_reg;
    logic [AW:0]   i_reg;
    logic [3:0]    h_reg;
    logic [3:0]    l_reg;
    logic [AW:0]   n_reg;
    logic [sorf_pkg::ScaleWidth-1:0] sc_reg;
    logic [SW-1:0] a_reg, rd_reg;
    logic [2:0]    srd_reg;
    logic [PW-1:0] prod_reg;
    logic [AW-1:0] ra_reg;
    logic          pv_reg, pl_reg;
    logic          m_valid_reg, m_valid_res_reg, m_sat_reg, m_last_reg;
    logic [SAMPLE_WIDTH-1:0] m_value_reg;
    logic          wb_reg;
    logic [SW-1:0] wbd_reg;
    logic [AW-1:0] wba_reg;

    logic [AW-1:0] ja, jb;
    logic [AW:0]   hh, lowmask;
    logic [SW:0]   rdx, negv;
    logic          vwe;
    logic [AW-1:0] vwa;
    logic [SW-1:0] vwd;
    logic [AW-1:0] vra;
    logic [SW:0]   rnd;
    logic [RW-1:0] rsh;
    logic signed [RW-1:0] hi_v, lo_v;
    logic          out_fire;

    assign hh = (AW+1)'(1) << h_reg;
    assign lowmask = hh - 1'b1;
    // pair index: insert a zero at bit h of the butterfly counter
    assign ja = AW'(((i_reg & ~lowmask) << 1) | (i_reg & lowmask));
    assign jb = AW'(((i_reg & ~lowmask) << 1) | (i_reg & lowmask) | hh);

    assign busy = st_reg != S_IDLE && st_reg != S_PL_RD && st_reg != S_PL_OUT;
    assign draining = !q_empty || st_reg == S_PL_RD || st_reg == S_PL_OUT;
    assign rdx  = {rd_reg[SW-1], rd_reg};
    assign negv = '0 - rdx;

    assign rnd  = rdx + (SW+1)'(128);
    assign rsh  = rnd[SW:8];
    assign hi_v = RW'((64'd1 << (SAMPLE_WIDTH-1)) - 1);
    assign lo_v = -hi_v - 1'b1;
    assign out_fire = st_reg == S_PL_OUT && (!m_valid_reg || m_ready);

    always_comb begin
        vwe = ld_we;
        vwa = ld_addr;
        vwd = ld_data;
        vra = ja;
        case (st_reg)
            S_SC_WR: begin
                vwe = 1'b1;
                vwa = i_reg[AW-1:0];
                vwd = prod_reg[SW+15:16];
            end
            S_BF_WR: begin
                vwe = 1'b1;
                vwa = ja;
                vwd = a_reg + rd_reg;
            end
            S_SC_RD: vra = i_reg[AW-1:0];
            S_BF_RD2: vra = jb;
            S_IDLE: vra = q_addr;
            S_PL_RD: vra = ra_reg;
            S_PL_OUT: vra = ra_reg;
            default: vra = ja;
        endcase
    end

    // lower butterfly output goes in on the cycle after the upper one
    always_ff @(posedge aclk) begin
        if (wb_reg) vmem[wba_reg] <= wbd_reg;
        else if (vwe) vmem[vwa] <= vwd;
        rd_reg <= vmem[vra];
        if (ld_we) smem[ld_addr] <= ld_signs;
        srd_reg <= smem[vra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
            wb_reg <= 1'b0;
        end else begin
            if (out_fire) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (st_reg)
                S_IDLE: begin
                    if (go) begin
                        st_reg <= S_SC_RD;
                        round_reg <= '0;
                        i_reg <= '0;
                        l_reg <= go_log2;
                        n_reg <= (AW+1)'(1) << go_log2;
                        sc_reg <= sorf_pkg::scale_q16({1'b0, go_log2});
                    end else if (!q_empty && !wb_reg) begin
                        pv_reg <= q_valid;
                        pl_reg <= q_last;
                        ra_reg <= q_addr;
                        st_reg <= S_PL_RD;
                    end
                end
                S_PL_RD: st_reg <= S_PL_OUT;
                S_PL_OUT: begin
                    if (out_fire) begin
                        m_valid_res_reg <= pv_reg;
                        m_last_reg <= pv_reg & pl_reg;
                        if (!pv_reg) begin
                            m_value_reg <= '0;
                            m_sat_reg <= 1'b0;
                        end else if ($signed(rsh) > hi_v) begin
                            m_value_reg <= hi_v[SAMPLE_WIDTH-1:0];
                            m_sat_reg <= 1'b1;
                        end else if ($signed(rsh) < lo_v) begin
                            m_value_reg <= lo_v[SAMPLE_WIDTH-1:0];
                            m_sat_reg <= 1'b1;
                        end else begin
                            m_value_reg <= rsh[SAMPLE_WIDTH-1:0];
                            m_sat_reg <= 1'b0;
                        end
                        st_reg <= S_IDLE;
                    end
                end
                S_SC_RD: st_reg <= S_SC_MUL;
                S_SC_MUL: begin
                    prod_reg <= ($signed(srd_reg[round_reg] ? negv : rdx)
                                * $signed({1'b0, sc_reg})) + PW'(32768);
                    st_reg <= S_SC_WR;
                end
                S_SC_WR: begin
                    if (i_reg + 1'b1 == n_reg) begin
                        i_reg <= '0;
                        h_reg <= '0;
                        st_reg <= S_BF_RD;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                        st_reg <= S_SC_RD;
                    end
                end
                S_BF_RD: st_reg <= S_BF_RD2;
                S_BF_RD2: begin
                    a_reg <= rd_reg;
                    st_reg <= S_BF_WR;
                end
                S_BF_WR: begin
                    wb_reg <= 1'b1;
                    wba_reg <= jb;
                    wbd_reg <= a_reg - rd_reg;
                    if (i_reg + 1'b1 == (n_reg >> 1)) begin
                        i_reg <= '0;
                        if (h_reg + 1'b1 == l_reg) begin
                            h_reg <= '0;
                            if (round_reg == 2'd2) st_reg <= S_IDLE;
                            else begin
                                round_reg <= round_reg + 1'b1;
                                st_reg <= S_SC_RD;
                            end
                        end else begin
                            h_reg <= h_reg + 1'b1;
                            st_reg <= S_BF_RD;
                        end
                    end else begin
                        i_reg <= i_reg + 1'b1;
                        st_reg <= S_BF_RD;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
            if (st_reg != S_BF_WR) wb_reg <= 1'b0;
        end
    end

    assign q_rd = st_reg == S_IDLE && !go && !q_empty && !wb_reg;
    assign m_valid     = m_valid_reg;
    assign m_valid_res = m_valid_res_reg;
    assign m_value     = m_value_reg;
    assign m_saturated = m_sat_reg;
    assign m_last      = m_last_reg;
endmodule
`default_nettype wire

FILE: sim/structured_orthogonal_random_features_tb.sv
// self-checking testbench for the three-round sign flip and hadamard transform block
// holds a bit-true predictor of the block inside a small scoreboard class
// depends on sorf_pkg and structured_orthogonal_random_features
`timescale 1ns / 100ps
module structured_orthogonal_random_features_tb;

    localparam int CycleLimit = 2000000;

    class sorf_scoreboard;
        typedef struct {
            logic        valid_res;
            logic [15:0] value;
            logic        saturated;
            logic        last;
        } pull_result_t;

        int unsigned  scale_tbl[11] = '{65536, 46341, 32768, 23170, 16384, 11585,
                                         8192, 5793, 4096, 2896, 2048};
        longint       vec[sorf_pkg::MaxLength];
        bit [2:0]     signs[sorf_pkg::MaxLength];
        int           load_cnt;
        int           drain_cnt;
        int           drain_len;
        bit           pending;
        bit [3:0]     len_reg;
        bit           kicked;
        int           errors;
        int           useful_items;
        pull_result_t expected_results[$];

        function new();
            load_cnt = 0;
            drain_cnt = 0;
            drain_len = 1;
            pending = 0;
            len_reg = 4'd10;
            kicked = 0;
            errors = 0;
            useful_items = 0;
        endfunction

        function longint wrap40(longint v);
            longint w;
            w = v <<< 24;
            return w >>> 24;
        endfunction

        function int eff_log2();
            int l;
            l = len_reg;
            if (l < 1) l = 1;
            if (l > 10) l = 10;
            while (l > 1 && (1 << l) > sorf_pkg::MaxLength) l--;
            return l;
        endfunction

        function int busy_cycles();
            int l;
            l = eff_log2();
            return 3 * (4 * drain_len + 2 * drain_len * l) + 64;
        endfunction

        function void write_len(logic [3:0] d);
            len_reg = d;
        endfunction

        function void hadamard_rounds(int n, int l);
            longint sc;
            longint v;
            longint a;
            longint c;
            sc = scale_tbl[l];
            for (int r = 0; r < 3; r++) begin
                for (int i = 0; i < n; i++) begin
                    v = vec[i];
                    if (signs[i][r]) v = -v;
                    vec[i] = wrap40((v * sc + 32768) >>> 16);
                end
                for (int h = 1; h < n; h = h * 2)
                    for (int b = 0; b < n; b += 2 * h)
                        for (int j = b; j < b + h; j++) begin
                            a = vec[j];
                            c = vec[j + h];
                            vec[j] = wrap40(a + c);
                            vec[j + h] = wrap40(a - c);
                        end
            end
        endfunction

        function void note_item(sorf_pkg::req_t req, logic [15:0] smp, logic [2:0] sg);
            int l;
            int n;
            longint v;
            pull_result_t e;
            if (req == sorf_pkg::REQ_PUSH) begin
                if (pending) return;
                useful_items++;
                l = eff_log2();
                n = 1 << l;
                if (load_cnt >= n) load_cnt = n - 1;
                v = $signed(smp);
                vec[load_cnt] = wrap40(v <<< 8);
                signs[load_cnt] = sg;
                load_cnt++;
                if (load_cnt == n) begin
                    hadamard_rounds(n, l);
                    pending = 1;
                    drain_cnt = 0;
                    drain_len = n;
                    load_cnt = 0;
                    kicked = 1;
                end
                return;
            end
            useful_items++;
            kicked = 0;
            e = '{1'b0, 16'd0, 1'b0, 1'b0};
            if (pending && drain_cnt < drain_len) begin
                v = (vec[drain_cnt] + 128) >>> 8;
                if (v > 32767) begin
                    v = 32767;
                    e.saturated = 1'b1;
                end
                if (v < -32768) begin
                    v = -32768;
                    e.saturated = 1'b1;
                end
                e.valid_res = 1'b1;
                e.value = v[15:0];
                e.last = (drain_cnt + 1 == drain_len);
                drain_cnt++;
                if (drain_cnt >= drain_len) begin
                    pending = 0;
                    drain_cnt = 0;
                    load_cnt = 0;
                end
            end
            expected_results.push_back(e);
        endfunction

        function void check_result(logic vr, logic [15:0] val, logic sat, logic lst);
            pull_result_t e;
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (vr !== e.valid_res) begin
                $error("valid_res: expected %0d, got %0d", e.valid_res, vr);
                errors++;
            end
            if (val !== e.value) begin
                $error("value: expected %0d, got %0d", $signed(e.value), $signed(val));
                errors++;
            end
            if (sat !== e.saturated) begin
                $error("saturated: expected %0d, got %0d", e.saturated, sat);
                errors++;
            end
            if (lst !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_req_type = 0;
    logic [15:0] s_sample = 0;
    logic        s_sign_first = 0;
    logic        s_sign_second = 0;
    logic        s_sign_third = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_valid_res;
    logic [15:0] m_value;
    logic        m_saturated;
    logic        m_last;

    sorf_scoreboard sb = new();
    int cycles = 0;
    int rx_wait = 0;
    int rx_draw;
    bit rx_burst = 0;
    bit tx_burst = 0;

    structured_orthogonal_random_features uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_sample(s_sample), .s_sign_first(s_sign_first),
        .s_sign_second(s_sign_second), .s_sign_third(s_sign_third),
        .m_valid(m_valid), .m_ready(m_ready), .m_valid_res(m_valid_res),
        .m_value(m_value), .m_saturated(m_saturated), .m_last(m_last)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_len(cfg_data);
            if (s_valid && s_ready)
                sb.note_item(sorf_pkg::req_t'(s_req_type), s_sample,
                             {s_sign_third, s_sign_second, s_sign_first});
            if (m_valid && m_ready)
                sb.check_result(m_valid_res, m_value, m_saturated, m_last);
        end
    end

    // result side stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (m_valid && m_ready) begin
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
            rx_draw = rx_burst ? 0 : $urandom_range(0, 14);
            m_ready <= (rx_draw == 0);
            rx_wait <= rx_draw - 1;
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(sorf_pkg::req_t req, logic [15:0] smp, logic [2:0] sg);
        int gap;
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_sample <= smp;
        {s_sign_third, s_sign_second, s_sign_first} <= sg;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic push_item(logic [15:0] smp, logic [2:0] sg);
        send_item(sorf_pkg::REQ_PUSH, smp, sg);
    endtask

    task automatic pull_item();
        send_item(sorf_pkg::REQ_PULL, 16'($urandom), 3'($urandom));
    endtask

    // wait until every pulled item is back and any transform has had time to finish
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
        if (sb.kicked) begin
            repeat (sb.busy_cycles()) @(posedge aclk);
            sb.kicked = 0;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_length(logic [3:0] d);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_vector(logic [3:0] d);
        int n;
        int k;
        write_length(d);
        n = 1 << sb.eff_log2();
        k = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : n;
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 19) == 0) pull_item();
            push_item(pick_sample(), 3'($urandom));
        end
        if ($urandom_range(0, 3) == 0) push_item(pick_sample(), 3'($urandom));
        for (int i = 0; i < k; i++) pull_item();
        if ($urandom_range(0, 3) == 0) pull_item();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // length clamped up, full scale inputs, dropped push, pulls before and after
        write_length(4'd0);
        pull_item();
        push_item(16'h7fff, 3'b000);
        push_item(16'h7fff, 3'b000);
        push_item(16'h8000, 3'b111);
        pull_item();
        pull_item();
        pull_item();
        write_length(4'd1);
        push_item(16'h8000, 3'b111);
        push_item(16'h8000, 3'b101);
        pull_item();
        pull_item();
        // length shrunk during load
        write_length(4'd2);
        push_item(16'h0001, 3'b010);
        push_item(16'hffff, 3'b100);
        push_item(16'h1234, 3'b011);
        write_length(4'd1);
        push_item(16'hedcb, 3'b110);
        pull_item();
        pull_item();
        // length changed while draining
        write_length(4'd0);
        push_item(16'h5555, 3'b001);
        push_item(16'haaaa, 3'b110);
        pull_item();
        write_length(4'd15);
        pull_item();

        while (sb.useful_items < 600) run_vector(4'($urandom_range(0, 6)));

        // length clamped down, partial load followed by pulls before results
        write_length(4'($urandom_range(10, 15)));
        for (int i = 0; i < 6; i++) push_item(pick_sample(), 3'($urandom));
        pull_item();
        pull_item();

        settle();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/sorf_pkg.sv
hw/rtl/sorf_front.sv
hw/rtl/sorf_queue.sv
hw/rtl/sorf_back.sv
hw/rtl/structured_orthogonal_random_features.sv
sim/structured_orthogonal_random_features_tb.sv
